>>> rtl/kex2xt_pkg.sv
// ----------------------------------------------------------------------------
// kex2xt_pkg - key event to XT scancode translator package
// Item types, key and scancode constants and lookup tables shared by the RTL.
// ----------------------------------------------------------------------------
package kex2xt_pkg;

	typedef struct packed {
		logic [7:0] key_code;
		logic [7:0] key_state;
	} key_event_t;

	typedef struct packed {
		logic [7:0] scancode;
		logic       last;
	} xt_code_t;

	// event states
	localparam logic [7:0] ST_PRESS   = 8'h01;
	localparam logic [7:0] ST_HOLD    = 8'h02;
	localparam logic [7:0] ST_RELEASE = 8'h03;

	// controller key codes
	localparam logic [7:0] KEY_ALT    = 8'hA1;
	localparam logic [7:0] KEY_LSHIFT = 8'hA2;
	localparam logic [7:0] KEY_RSHIFT = 8'hA3;
	localparam logic [7:0] KEY_SYM    = 8'hA4;
	localparam logic [7:0] KEY_CTRL   = 8'hA5;
	localparam logic [7:0] KEY_F1     = 8'h81;
	localparam logic [7:0] KEY_F2     = 8'h82;
	localparam logic [7:0] KEY_F3     = 8'h83;
	localparam logic [7:0] KEY_F9     = 8'h89;
	localparam logic [7:0] KEY_F10    = 8'h90;
	localparam logic [7:0] KEY_PRINT_LO = 8'h20;
	localparam logic [7:0] KEY_PRINT_HI = 8'h7E;

	// XT set-1 codes
	localparam logic [7:0] XT_BRK_BIT = 8'h80;
	localparam logic [7:0] XT_LSH     = 8'h2A;
	localparam logic [7:0] XT_RSH     = 8'h36;
	localparam logic [7:0] XT_CTRL    = 8'h1D;
	localparam logic [7:0] XT_ALT     = 8'h38;
	localparam logic [7:0] XT_F1      = 8'h3B;
	localparam logic [7:0] XT_F10     = 8'h44;
	localparam logic [7:0] XT_KP_MUL  = 8'h37;
	localparam logic [7:0] XT_KP_SUB  = 8'h4A;
	localparam logic [7:0] XT_KP_ADD  = 8'h4E;
	localparam logic [7:0] XT_NONE    = 8'h00;

	localparam int PRINT_ROM_DEPTH = 95;

	// printable ASCII from space; bit 7 marks a character that needs Shift
	localparam logic [7:0] PRINT_ROM [PRINT_ROM_DEPTH] = '{
		8'h39, 8'h82, 8'hA8, 8'h84, 8'h85, 8'h86, 8'h88, 8'h28, 8'h8A, 8'h8B,
		8'h89, 8'h8D, 8'h33, 8'h0C, 8'h34, 8'h35,
		8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
		8'hA7, 8'h27, 8'hB3, 8'h0D, 8'hB4, 8'hB5, 8'h83,
		8'h9E, 8'hB0, 8'hAE, 8'hA0, 8'h92, 8'hA1, 8'hA2, 8'hA3, 8'h97, 8'hA4,
		8'hA5, 8'hA6, 8'hB2, 8'hB1, 8'h98, 8'h99, 8'h90, 8'h93, 8'h9F, 8'h94,
		8'h96, 8'hAF, 8'h91, 8'hAD, 8'h95, 8'hAC,
		8'h1A, 8'h2B, 8'h1B, 8'h87, 8'h8C, 8'h29,
		8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
		8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
		8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C,
		8'h9A, 8'hAB, 8'h9B, 8'hA9
	};

	// XT code for a non-printable key, XT_NONE where there is none
	function automatic logic [7:0] special_code(input logic [7:0] k);
		logic [7:0] code;
		code = XT_NONE;
		case (k) inside
			8'h08:            code = 8'h0E;
			8'h09:            code = 8'h0F;
			8'h0A:            code = 8'h1C;
			8'hB1:            code = 8'h01;
			8'hB4:            code = 8'h4B;
			8'hB5:            code = 8'h48;
			8'hB6:            code = 8'h50;
			8'hB7:            code = 8'h4D;
			8'hC1:            code = 8'h3A;
			8'hD0:            code = 8'h46;
			8'hD1:            code = 8'h52;
			8'hD2:            code = 8'h47;
			8'hD4:            code = 8'h53;
			8'hD5:            code = 8'h4F;
			8'hD6:            code = 8'h49;
			8'hD7:            code = 8'h51;
			[KEY_F1:KEY_F9]:  code = XT_F1 + (k - KEY_F1);
			KEY_F10:          code = XT_F10;
			default:          code = XT_NONE;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/key_event_to_xt_scancode.sv
// ----------------------------------------------------------------------------
// key_event_to_xt_scancode - key event to PC/XT set-1 scancode translator
// Turns press, hold and release events into make and break codes, with
// modifier tracking, hotkeys and synthesised left-Shift around characters.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_ready   | in_data  : key_code, key_state
//  out     | out_valid / out_ready | out_data : scancode, last
//
// An accepted item sits in the input register, where its scancodes and the next modifier
// state are formed and loaded into a two-entry result buffer; the first scancode is
// offered in the cycle after the load. The single result port sets the rate: one item
// per cycle unless the output stalls, an item giving two scancodes holding it for both;
// items giving none never wait on it. Reset clears all modifier flags and empties both
// stages. A stalled output holds the buffer and items giving scancodes; in_ready drops.
// ----------------------------------------------------------------------------
module key_event_to_xt_scancode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  kex2xt_pkg::key_event_t in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output kex2xt_pkg::xt_code_t   out_data
);
	import kex2xt_pkg::*;

	// input register
	logic       valid_s1;
	key_event_t ev_s1;

	// modifier state
	logic phys_shift_q, fake_shift_q, ctrl_q, alt_q;

	// result buffer: entry 0 is on the output
	xt_code_t   buf0_q, buf1_q;
	logic [1:0] cnt_q;

	// translation of the item in the input register
	logic [1:0] res_n;
	logic [7:0] res0, res1;
	logic       phys_shift_d, fake_shift_d, ctrl_d, alt_d;

	logic       state_ok, down, is_mod, hot_key;
	logic [7:0] code, spec, rom_e;
	logic [6:0] rom_idx;
	logic       need_shift, printable;

	logic out_fire, buf_free, advance;

	always_comb begin
		state_ok = (ev_s1.key_state == ST_PRESS) || (ev_s1.key_state == ST_HOLD) ||
			(ev_s1.key_state == ST_RELEASE);
		down     = (ev_s1.key_state != ST_RELEASE);
		is_mod   = (ev_s1.key_code == KEY_ALT) || (ev_s1.key_code == KEY_LSHIFT) ||
			(ev_s1.key_code == KEY_RSHIFT) || (ev_s1.key_code == KEY_CTRL);
		hot_key  = ctrl_q && alt_q && ((ev_s1.key_code == KEY_F1) ||
			(ev_s1.key_code == KEY_F2) || (ev_s1.key_code == KEY_F3));
		spec      = special_code(ev_s1.key_code);
		printable = (ev_s1.key_code >= KEY_PRINT_LO) && (ev_s1.key_code <= KEY_PRINT_HI);
		rom_idx   = 7'(ev_s1.key_code - KEY_PRINT_LO);
		rom_e     = printable ? PRINT_ROM[rom_idx] : XT_NONE;

		phys_shift_d = phys_shift_q;
		fake_shift_d = fake_shift_q;
		ctrl_d       = ctrl_q;
		alt_d        = alt_q;
		res_n        = 2'd0;
		res0         = XT_NONE;
		res1         = XT_NONE;
		code         = XT_NONE;
		need_shift   = 1'b0;

		if (!state_ok) begin
			// drop: invalid event state
		end else if (is_mod) begin
			// pass modifiers through; drop their hold repeats
			if (ev_s1.key_state != ST_HOLD) begin
				case (ev_s1.key_code)
					KEY_CTRL: begin
						ctrl_d = down;
						code   = XT_CTRL;
					end
					KEY_ALT: begin
						alt_d = down;
						code  = XT_ALT;
					end
					KEY_LSHIFT: begin
						phys_shift_d = down;
						code         = XT_LSH;
					end
					default: begin
						phys_shift_d = down;
						code         = XT_RSH;
					end
				endcase
				res_n = 2'd1;
				res0  = down ? code : (code | XT_BRK_BIT);
			end
		end else if (ev_s1.key_code == KEY_SYM) begin
			// swallow Sym
		end else begin
			if (hot_key) begin
				case (ev_s1.key_code)
					KEY_F1:  code = XT_KP_MUL;
					KEY_F2:  code = XT_KP_SUB;
					default: code = XT_KP_ADD;
				endcase
			end else if (spec != XT_NONE) begin
				code = spec;
			end else if (printable) begin
				code       = rom_e & ~XT_BRK_BIT;
				need_shift = rom_e[7];
			end

			if (hot_key || spec != XT_NONE || printable) begin
				if (down) begin
					if (need_shift && !phys_shift_q && !fake_shift_q) begin
						fake_shift_d = 1'b1;
						res_n        = 2'd2;
						res0         = XT_LSH;
						res1         = code;
					end else begin
						res_n = 2'd1;
						res0  = code;
					end
				end else begin
					res0 = code | XT_BRK_BIT;
					if (fake_shift_q) begin
						// close the synthesised Shift after the release of any translated key
						fake_shift_d = 1'b0;
						res_n        = 2'd2;
						res1         = XT_LSH | XT_BRK_BIT;
					end else begin
						res_n = 2'd1;
					end
				end
			end
		end
	end

	// handshakes
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf0_q;
	assign out_fire  = out_valid && out_ready;
	assign buf_free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign advance   = valid_s1 && ((res_n == 2'd0) || buf_free);
	assign in_ready  = !valid_s1 || advance;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			cnt_q        <= 2'd0;
			phys_shift_q <= 1'b0;
			fake_shift_q <= 1'b0;
			ctrl_q       <= 1'b0;
			alt_q        <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phys_shift_q <= phys_shift_d;
				fake_shift_q <= fake_shift_d;
				ctrl_q       <= ctrl_d;
				alt_q        <= alt_d;
			end
			if (advance && res_n != 2'd0) begin
				cnt_q <= res_n;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// payload: load the input register from in_data; load the buffer from the input register, else advance it
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ev_s1 <= in_data;
		end
		if (advance && res_n != 2'd0) begin
			buf0_q.scancode <= res0;
			buf0_q.last     <= (res_n == 2'd1);
			buf1_q.scancode <= res1;
			buf1_q.last     <= 1'b1;
		end else if (out_fire) begin
			buf0_q <= buf1_q;
		end
	end

endmodule
